// File: design/flvavd_pkg.sv
// Package: shared constants and types for the FLV audio/video splitter.
package flvavd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned LenW       = 24;
  localparam int unsigned PrevW      = 25;
  localparam int unsigned RunMax     = 5;
  localparam int unsigned RunCntW    = 3;
  localparam int unsigned FileHdrLen = 9;
  localparam int unsigned TagHdrLen  = 15;
  localparam int unsigned TagOvhd    = 11;
  localparam int unsigned TypePos    = 4;
  localparam int unsigned LenPos0    = 5;
  localparam int unsigned LenPos1    = 6;
  localparam int unsigned LenPos2    = 7;

  localparam logic [ByteW-1:0] TypeAudio = 8'd8;
  localparam logic [ByteW-1:0] TypeVideo = 8'd9;

  typedef enum logic [1:0] {
    KIND_META  = 2'd0,
    KIND_AUDIO = 2'd1,
    KIND_VIDEO = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

endpackage

// File: design/flv_audio_video_demux_core.sv
// Top level: FLV byte-stream splitter into audio-only and video-only streams.
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_ready_o   | in_byte_i, start_of_file_i
//  out     | output    | out_valid_o / out_ready_i | out_byte_o, to_audio_o,
//          |           |                           | to_video_o, last_of_run_o
//
// Parsing is done in the cycle a word is accepted; its results (0, 1 or 5)
// land in a 5-byte run buffer that drains one word per cycle while out_ready_i is high.
// Words with 0 or 1 result flow at one per cycle while out_ready_i is high; a type
// byte of an audio or video tag holds the input while its run drains.
// rst_ni clears the parser and empties the run buffer.
// A stalled output holds the buffer; the input is taken once the last word
// of the current run leaves.
module flv_audio_video_demux_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       start_of_file_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       to_audio_o,
  output logic       to_video_o,
  output logic       last_of_run_o
);
  import flvavd_pkg::*;

  typedef enum logic [1:0] {
    PH_FILE   = 2'd0,
    PH_TAGHDR = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

  localparam int unsigned BufW = RunMax * ByteW;

  phase_e            phase_q, phase_d;
  logic [LenW-1:0]   pos_q, pos_d;
  kind_e             kind_q, kind_d;
  logic [LenW-1:0]   body_q, body_d;
  logic [PrevW-1:0]  aprev_q, aprev_d;
  logic [PrevW-1:0]  vprev_q, vprev_d;
  logic              ftd_q, ftd_d;

  logic [BufW-1:0]    buf_q, buf_d;
  logic [RunCntW-1:0] cnt_q, cnt_d;
  logic               to_audio_q, to_audio_d;
  logic               to_video_q, to_video_d;

  // effective state after an optional restart
  phase_e           cur_phase;
  logic [LenW-1:0]  cur_pos;
  kind_e            cur_kind;
  logic [LenW-1:0]  cur_body;
  logic [PrevW-1:0] cur_aprev;
  logic [PrevW-1:0] cur_vprev;
  logic             cur_ftd;

  logic [RunCntW-1:0] res_n;
  logic [BufW-1:0]    res_word;
  logic               res_a, res_v;
  logic [LenW-1:0]    pos_inc;
  logic [PrevW-1:0]   sz;

  logic in_acc, out_acc;

  assign out_valid_o   = (cnt_q != '0);
  assign in_ready_o    = (cnt_q == '0) || ((cnt_q == RunCntW'(1)) && out_ready_i);
  assign in_acc        = in_valid_i && in_ready_o;
  assign out_acc       = out_valid_o && out_ready_i;
  assign out_byte_o    = buf_q[BufW-1 -: ByteW];
  assign to_audio_o    = to_audio_q;
  assign to_video_o    = to_video_q;
  assign last_of_run_o = (cnt_q == RunCntW'(1));

  always_comb begin
    cur_phase = start_of_file_i ? PH_FILE    : phase_q;
    cur_pos   = start_of_file_i ? '0         : pos_q;
    cur_kind  = start_of_file_i ? KIND_META  : kind_q;
    cur_body  = start_of_file_i ? '0         : body_q;
    cur_aprev = start_of_file_i ? '0         : aprev_q;
    cur_vprev = start_of_file_i ? '0         : vprev_q;
    cur_ftd   = start_of_file_i ? 1'b0       : ftd_q;

    phase_d  = cur_phase;
    pos_d    = cur_pos;
    kind_d   = cur_kind;
    body_d   = cur_body;
    aprev_d  = cur_aprev;
    vprev_d  = cur_vprev;
    ftd_d    = cur_ftd;
    res_n    = '0;
    res_a    = 1'b0;
    res_v    = 1'b0;
    res_word = {in_byte_i, {(BufW-ByteW){1'b0}}};
    pos_inc  = cur_pos + LenW'(1);
    sz       = '0;

    unique case (cur_phase)
      PH_TAGHDR: begin
        if (!cur_ftd) begin
          kind_d = KIND_META;
          res_n  = RunCntW'(1);
          res_a  = 1'b1;
          res_v  = 1'b1;
        end else if (cur_pos == LenW'(TypePos)) begin
          if (in_byte_i == TypeAudio) begin
            kind_d = KIND_AUDIO;
            sz     = cur_aprev;
            res_a  = 1'b1;
          end else if (in_byte_i == TypeVideo) begin
            kind_d = KIND_VIDEO;
            sz     = cur_vprev;
            res_v  = 1'b1;
          end else begin
            kind_d = KIND_OTHER;
          end
          if (kind_d != KIND_OTHER) begin
            res_n    = RunCntW'(RunMax);
            res_word = {7'd0, sz, in_byte_i};
          end
        end else if (cur_pos > LenW'(TypePos)) begin
          res_n = (cur_kind == KIND_OTHER) ? '0 : RunCntW'(1);
          res_a = (cur_kind == KIND_META) || (cur_kind == KIND_AUDIO);
          res_v = (cur_kind == KIND_META) || (cur_kind == KIND_VIDEO);
        end
        if (cur_pos == LenW'(LenPos0)) begin
          body_d = LenW'(in_byte_i);
        end else if (cur_pos == LenW'(LenPos1) || cur_pos == LenW'(LenPos2)) begin
          body_d = {cur_body[LenW-ByteW-1:0], in_byte_i};
        end
        pos_d = pos_inc;
        if (pos_inc >= LenW'(TagHdrLen)) begin
          if (!cur_ftd) begin
            aprev_d = PrevW'(body_d) + PrevW'(TagOvhd);
            vprev_d = PrevW'(body_d) + PrevW'(TagOvhd);
            ftd_d   = 1'b1;
          end else if (kind_d == KIND_AUDIO) begin
            aprev_d = PrevW'(body_d) + PrevW'(TagOvhd);
          end else if (kind_d == KIND_VIDEO) begin
            vprev_d = PrevW'(body_d) + PrevW'(TagOvhd);
          end
          phase_d = (body_d == '0) ? PH_TAGHDR : PH_BODY;
          pos_d   = '0;
        end
      end
      PH_BODY: begin
        res_n = (cur_kind == KIND_OTHER) ? '0 : RunCntW'(1);
        res_a = (cur_kind == KIND_META) || (cur_kind == KIND_AUDIO);
        res_v = (cur_kind == KIND_META) || (cur_kind == KIND_VIDEO);
        pos_d = pos_inc;
        if (pos_inc >= cur_body) begin
          phase_d = PH_TAGHDR;
          pos_d   = '0;
        end
      end
      default: begin
        phase_d = PH_FILE;
        res_n   = RunCntW'(1);
        res_a   = 1'b1;
        res_v   = 1'b1;
        pos_d   = pos_inc;
        if (pos_inc >= LenW'(FileHdrLen)) begin
          phase_d = PH_TAGHDR;
          pos_d   = '0;
        end
      end
    endcase
  end

  always_comb begin
    buf_d      = buf_q;
    cnt_d      = cnt_q;
    to_audio_d = to_audio_q;
    to_video_d = to_video_q;
    if (out_acc) begin
      buf_d = {buf_q[BufW-ByteW-1:0], {ByteW{1'b0}}};
      cnt_d = cnt_q - RunCntW'(1);
    end
    if (in_acc) begin
      cnt_d = res_n;
      if (res_n != '0) begin
        buf_d      = res_word;
        to_audio_d = res_a;
        to_video_d = res_v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_FILE;
      pos_q      <= '0;
      kind_q     <= KIND_META;
      body_q     <= '0;
      aprev_q    <= '0;
      vprev_q    <= '0;
      ftd_q      <= 1'b0;
      buf_q      <= '0;
      cnt_q      <= '0;
      to_audio_q <= 1'b0;
      to_video_q <= 1'b0;
    end else begin
      buf_q      <= buf_d;
      cnt_q      <= cnt_d;
      to_audio_q <= to_audio_d;
      to_video_q <= to_video_d;
      if (in_acc) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        kind_q  <= kind_d;
        body_q  <= body_d;
        aprev_q <= aprev_d;
        vprev_q <= vprev_d;
        ftd_q   <= ftd_d;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RunCntW'(RunMax))
    else $error("run count out of range");

  a_busy_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > RunCntW'(1)) |-> !in_ready_o)
    else $error("input taken while run pending");

  a_has_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (to_audio_q || to_video_q))
    else $error("word with no target stream");

  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (body_q != '0))
    else $error("body phase with empty body");

endmodule
